// ===== hdl/lcs_pkg.sv =====
// ----------------------------------------------------------------------------
// lcs_pkg: shared definitions for the longest common subsequence block
// Operation codes, fixed field widths and the control flags of a queue word.
// ----------------------------------------------------------------------------
package lcs_pkg;

  localparam int SYM_W     = 8;
  localparam int OUT_LEN_W = 6;

  localparam logic OP_FIRST  = 1'b0;
  localparam logic OP_SECOND = 1'b1;

  // control flags of one queued word
  typedef struct packed {
    logic run;  // second string ended: start the table fill
    logic wr;   // symbol is stored
    logic sel;  // target string, an OP_* code
  } lcs_ctl_t;

  localparam int CTL_W = $bits(lcs_ctl_t);

endpackage

// ===== hdl/lcs_front.sv =====
// ----------------------------------------------------------------------------
// lcs_front: input classification
// Tracks both string lengths, decides store address or drop for each symbol,
// and marks the word that ends the second string as a run request.
// ----------------------------------------------------------------------------
module lcs_front #(
  parameter int MAX_LEN = 32,
  parameter int CW      = $clog2(MAX_LEN + 1)
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    valid_i,
  output logic                    stall_o,
  input  logic                    operation_i,
  input  logic [lcs_pkg::SYM_W-1:0] symbol_i,
  input  logic                    end_of_string_i,
  input  logic                    full_i,
  output logic                    push_o,
  output lcs_pkg::lcs_ctl_t       ctl_o,
  output logic [CW-1:0]           addr_o,
  output logic [lcs_pkg::SYM_W-1:0] sym_o,
  output logic [CW-1:0]           m_o,
  output logic [CW-1:0]           n_o
);
  import lcs_pkg::*;

  logic [CW-1:0] first_q, first_d;
  logic [CW-1:0] second_q, second_d;
  logic [CW-1:0] cnt_sel;
  logic          room;

  assign stall_o = full_i;
  assign push_o  = valid_i && !full_i;
  assign cnt_sel = (operation_i == OP_SECOND) ? second_q : first_q;
  assign room    = cnt_sel < CW'(MAX_LEN);

  always_comb begin
    ctl_o.run = (operation_i == OP_SECOND) && end_of_string_i;
    ctl_o.wr  = room;
    ctl_o.sel = operation_i;
  end

  assign addr_o = cnt_sel;
  assign sym_o  = symbol_i;
  assign m_o    = first_q;
  assign n_o    = (room && operation_i == OP_SECOND) ? second_q + 1'b1 : second_q;

  always_comb begin
    first_d  = first_q;
    second_d = second_q;
    if (push_o) begin
      if (ctl_o.run) begin
        first_d  = '0;
        second_d = '0;
      end else if (room) begin
        if (operation_i == OP_SECOND) begin
          second_d = second_q + 1'b1;
        end else begin
          first_d = first_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q  <= '0;
      second_q <= '0;
    end else begin
      first_q  <= first_d;
      second_q <= second_d;
    end
  end

endmodule

// ===== hdl/lcs_fifo.sv =====
// ----------------------------------------------------------------------------
// lcs_fifo: two-word queue
// Decouples classification from table work; full and empty from a count.
// ----------------------------------------------------------------------------
module lcs_fifo #(
  parameter int WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [WIDTH-1:0] data_o
);
  import lcs_pkg::*;

  logic [WIDTH-1:0] mem_q [2];
  logic             wptr_q, rptr_q;
  logic [1:0]       cnt_q;

  assign full_o  = cnt_q == 2'd2;
  assign valid_o = cnt_q != 2'd0;
  assign data_o  = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (push_i) begin
        wptr_q <= ~wptr_q;
      end
      if (pop_i) begin
        rptr_q <= ~rptr_q;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

endmodule

// ===== hdl/lcs_back.sv =====
// ----------------------------------------------------------------------------
// lcs_back: string stores, table fill and traceback
// Stores queued symbols; on a run request fills the length table cell by
// cell (read, write), then walks back from the far corner emitting matches.
// ----------------------------------------------------------------------------
module lcs_back #(
  parameter int MAX_LEN = 32,
  parameter int CW      = $clog2(MAX_LEN + 1)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          q_valid_i,
  output logic                          q_pop_o,
  input  lcs_pkg::lcs_ctl_t             q_ctl_i,
  input  logic [CW-1:0]                 q_addr_i,
  input  logic [lcs_pkg::SYM_W-1:0]     q_sym_i,
  input  logic [CW-1:0]                 q_m_i,
  input  logic [CW-1:0]                 q_n_i,
  output logic                          valid_o,
  input  logic                          stall_i,
  output logic [lcs_pkg::SYM_W-1:0]     common_symbol_o,
  output logic                          symbol_valid_o,
  output logic [lcs_pkg::OUT_LEN_W-1:0] subsequence_length_o,
  output logic                          run_last_o
);
  import lcs_pkg::*;

  localparam int AW    = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int DEPTH = MAX_LEN * MAX_LEN;
  localparam int TW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_FRD   = 3'd1;
  localparam logic [2:0] S_FWR   = 3'd2;
  localparam logic [2:0] S_TRD   = 3'd3;
  localparam logic [2:0] S_TDEC  = 3'd4;
  localparam logic [2:0] S_EMPTY = 3'd5;

  logic [SYM_W-1:0] a_mem [MAX_LEN];
  logic [SYM_W-1:0] b_mem [MAX_LEN];
  logic [CW-1:0]    t_mem [DEPTH];

  logic [2:0]       state_q, state_d;
  logic [CW-1:0]    m_q, m_d, n_q, n_d, i_q, i_d, j_q, j_d;
  logic [CW-1:0]    left_q, left_d, diag_q, diag_d, total_q, total_d, emit_q, emit_d;

  logic [SYM_W-1:0] a_rd_q, b_rd_q;
  logic [CW-1:0]    ta_q, tb_q;
  logic [CW-1:0]    im1, jm1;
  logic [TW-1:0]    ta_addr, tb_addr, tw_addr;
  logic             t_we, s_we;
  logic [CW-1:0]    up_v, left_v, cell_v;
  logic             match, can_load, load;
  logic [SYM_W-1:0] load_sym;
  logic             load_sv, load_last;

  logic             out_valid_q;
  logic [SYM_W-1:0] out_sym_q;
  logic             out_sv_q, out_last_q;
  logic [CW-1:0]    out_len_q;

  function automatic logic [TW-1:0] cell_addr(input logic [CW-1:0] r, input logic [CW-1:0] c);
    return TW'(r) * TW'(MAX_LEN) + TW'(c) - TW'(MAX_LEN + 1);
  endfunction

  assign im1     = i_q - 1'b1;
  assign jm1     = j_q - 1'b1;
  assign ta_addr = cell_addr(im1, j_q);
  assign tb_addr = cell_addr(i_q, jm1);
  assign tw_addr = cell_addr(i_q, j_q);

  assign q_pop_o = (state_q == S_IDLE) && q_valid_i;
  assign s_we    = q_pop_o && q_ctl_i.wr;

  always_ff @(posedge clk_i) begin
    if (s_we && q_ctl_i.sel == OP_FIRST) begin
      a_mem[q_addr_i[AW-1:0]] <= q_sym_i;
    end
    if (s_we && q_ctl_i.sel == OP_SECOND) begin
      b_mem[q_addr_i[AW-1:0]] <= q_sym_i;
    end
  end

  always_ff @(posedge clk_i) begin
    a_rd_q <= a_mem[im1[AW-1:0]];
    b_rd_q <= b_mem[jm1[AW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (t_we) begin
      t_mem[tw_addr] <= cell_v;
    end
  end

  always_ff @(posedge clk_i) begin
    ta_q <= t_mem[ta_addr];
    tb_q <= t_mem[tb_addr];
  end

  // row 0 and column 0 of the table are implicit zeros
  assign up_v     = (i_q == CW'(1)) ? '0 : ta_q;
  assign left_v   = (j_q == CW'(1)) ? '0 : tb_q;
  assign match    = a_rd_q == b_rd_q;
  assign cell_v   = match ? diag_q + 1'b1 : ((up_v > left_q) ? up_v : left_q);
  assign can_load = !out_valid_q || !stall_i;

  always_comb begin
    state_d   = state_q;
    m_d       = m_q;
    n_d       = n_q;
    i_d       = i_q;
    j_d       = j_q;
    left_d    = left_q;
    diag_d    = diag_q;
    total_d   = total_q;
    emit_d    = emit_q;
    t_we      = 1'b0;
    load      = 1'b0;
    load_sym  = '0;
    load_sv   = 1'b0;
    load_last = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (q_pop_o && q_ctl_i.run) begin
          m_d     = q_m_i;
          n_d     = q_n_i;
          i_d     = CW'(1);
          j_d     = CW'(1);
          left_d  = '0;
          diag_d  = '0;
          total_d = '0;
          if (q_m_i == '0 || q_n_i == '0) begin
            state_d = S_EMPTY;
          end else begin
            state_d = S_FRD;
          end
        end
      end
      S_FRD: begin
        state_d = S_FWR;
      end
      S_FWR: begin
        t_we    = 1'b1;
        state_d = S_FRD;
        if (j_q == n_q) begin
          j_d    = CW'(1);
          left_d = '0;
          diag_d = '0;
          if (i_q == m_q) begin
            total_d = cell_v;
            i_d     = m_q;
            j_d     = n_q;
            emit_d  = '0;
            state_d = (cell_v == '0) ? S_EMPTY : S_TRD;
          end else begin
            i_d = i_q + 1'b1;
          end
        end else begin
          j_d    = j_q + 1'b1;
          left_d = cell_v;
          diag_d = up_v;
        end
      end
      S_TRD: begin
        state_d = S_TDEC;
      end
      S_TDEC: begin
        if (match) begin
          if (can_load) begin
            load      = 1'b1;
            load_sym  = a_rd_q;
            load_sv   = 1'b1;
            load_last = (emit_q + 1'b1) == total_q;
            emit_d    = emit_q + 1'b1;
            i_d       = im1;
            j_d       = jm1;
            state_d   = load_last ? S_IDLE : S_TRD;
          end
        end else if (up_v > left_v) begin
          i_d     = im1;
          state_d = S_TRD;
        end else begin
          j_d     = jm1;
          state_d = S_TRD;
        end
      end
      S_EMPTY: begin
        if (can_load) begin
          load      = 1'b1;
          load_last = 1'b1;
          state_d   = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (!stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    m_q     <= m_d;
    n_q     <= n_d;
    i_q     <= i_d;
    j_q     <= j_d;
    left_q  <= left_d;
    diag_q  <= diag_d;
    total_q <= total_d;
    emit_q  <= emit_d;
    if (load) begin
      out_sym_q  <= load_sym;
      out_sv_q   <= load_sv;
      out_last_q <= load_last;
      out_len_q  <= total_q;
    end
  end

  assign valid_o              = out_valid_q;
  assign common_symbol_o      = out_sym_q;
  assign symbol_valid_o       = out_sv_q;
  assign subsequence_length_o = OUT_LEN_W'(out_len_q);
  assign run_last_o           = out_last_q;

endmodule

// ===== hdl/longest_common_subsequence.sv =====
// ----------------------------------------------------------------------------
// longest_common_subsequence: LCS of two byte strings
// Loads two strings, fills the length table and emits the common
// subsequence in traceback order.
// ----------------------------------------------------------------------------
// Each symbol word is taken into a two-word queue; the front
// keeps accepting while the back is busy until that queue is full. A word
// that ends the second string (m and n symbols) starts a run: the table
// fill takes a read state and a write state of the single length table
// memory per cell, then each traceback step takes a read state and a
// decide state (at most m+n-1 steps) plus any output stall. A run emits
// max(1, LCS length) words and clears both strings. Symbols beyond
// MAX_LEN are dropped. No clearing pass is needed after reset.
module longest_common_subsequence #(
  parameter int MAX_LEN = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  output logic                          stall_o,
  input  logic                          operation_i,
  input  logic [lcs_pkg::SYM_W-1:0]     symbol_i,
  input  logic                          end_of_string_i,
  output logic                          valid_o,
  input  logic                          stall_i,
  output logic [lcs_pkg::SYM_W-1:0]     common_symbol_o,
  output logic                          symbol_valid_o,
  output logic [lcs_pkg::OUT_LEN_W-1:0] subsequence_length_o,
  output logic                          run_last_o
);
  import lcs_pkg::*;

  localparam int CW = $clog2(MAX_LEN + 1);
  localparam int WW = CTL_W + 3 * CW + SYM_W;

  logic             push, full, q_valid, q_pop;
  lcs_ctl_t         f_ctl, q_ctl;
  logic [CW-1:0]    f_addr, f_m, f_n, q_addr, q_m, q_n;
  logic [SYM_W-1:0] f_sym, q_sym;
  logic [WW-1:0]    f_word, q_word;

  lcs_front #(.MAX_LEN(MAX_LEN), .CW(CW)) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .valid_i         (valid_i),
    .stall_o         (stall_o),
    .operation_i     (operation_i),
    .symbol_i        (symbol_i),
    .end_of_string_i (end_of_string_i),
    .full_i          (full),
    .push_o          (push),
    .ctl_o           (f_ctl),
    .addr_o          (f_addr),
    .sym_o           (f_sym),
    .m_o             (f_m),
    .n_o             (f_n)
  );

  assign f_word = {f_ctl, f_addr, f_sym, f_m, f_n};

  lcs_fifo #(.WIDTH(WW)) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (f_word),
    .full_o  (full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .data_o  (q_word)
  );

  assign {q_ctl, q_addr, q_sym, q_m, q_n} = q_word;

  lcs_back #(.MAX_LEN(MAX_LEN), .CW(CW)) u_back (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .q_valid_i            (q_valid),
    .q_pop_o              (q_pop),
    .q_ctl_i              (q_ctl),
    .q_addr_i             (q_addr),
    .q_sym_i              (q_sym),
    .q_m_i                (q_m),
    .q_n_i                (q_n),
    .valid_o              (valid_o),
    .stall_i              (stall_i),
    .common_symbol_o      (common_symbol_o),
    .symbol_valid_o       (symbol_valid_o),
    .subsequence_length_o (subsequence_length_o),
    .run_last_o           (run_last_o)
  );

endmodule
